FILE: rtl/core/ldrt_pkg.sv
// Package with the sizes, limits and helper functions of the distinct-run tracker.
package ldrt_pkg;

   localparam int POS_BITS      = 16;
   localparam int ALPHABET_SIZE = 256;
   localparam int SYM_W         = $clog2(ALPHABET_SIZE);
   localparam int CH_W          = 8;
   localparam int LEN_W         = 16;
   localparam int LEN_CALC_W    = (POS_BITS + 1 > LEN_W + 1) ? POS_BITS + 1 : LEN_W + 1;

   localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};
   localparam logic [LEN_W-1:0]    LEN_MAX = {LEN_W{1'b1}};

   // A rounded-up reciprocal with 16 fraction bits gives the exact quotient of any byte.
   localparam int                  RECIP_SHIFT = 16;
   localparam logic [RECIP_SHIFT:0] SYM_RECIP  =
      (RECIP_SHIFT+1)'(((1 << RECIP_SHIFT) + ALPHABET_SIZE - 1) / ALPHABET_SIZE);

   // Folds a byte into the alphabet by multiplying with the reciprocal of its size.
   function automatic logic [SYM_W-1:0] sym_of(input logic [CH_W-1:0] ch);
      logic [CH_W+RECIP_SHIFT:0] prod;
      logic [CH_W-1:0]           quot;
      logic [CH_W+8:0]           rem;
      prod = (CH_W+RECIP_SHIFT+1)'(ch) * (CH_W+RECIP_SHIFT+1)'(SYM_RECIP);
      quot = prod[CH_W+RECIP_SHIFT-1:RECIP_SHIFT];
      rem  = (CH_W+9)'(ch) - (CH_W+9)'(quot) * (CH_W+9)'(ALPHABET_SIZE);
      return rem[SYM_W-1:0];
   endfunction

endpackage

FILE: rtl/core/longest_distinct_run_tracker.sv
// Top level of the longest distinct-byte run tracker.
//
//   channel   direction   handshake            payload
//   req_      in          req_valid/req_stall  ch, first
//   rsp_      out         rsp_valid/rsp_stall  window_len, longest_len, overflow
//
// An item's result is offered from the result register: the last-position
// memory is read at the accepting edge into the update stage, and the update
// and the write back into it happen when that stage advances into the result register.
// Items are accepted every cycle while the input side is not stalled; the memory read is bypassed from the write
// of the item ahead when both use the same byte value.
// Reset is synchronous and clears the seen bits and all counters at once.
// A stalled result holds the update stage, which then stalls the input side.
module longest_distinct_run_tracker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [ldrt_pkg::CH_W-1:0]   req_ch,
   input  logic                        req_first,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [ldrt_pkg::LEN_W-1:0]  rsp_window_len,
   output logic [ldrt_pkg::LEN_W-1:0]  rsp_longest_len,
   output logic                        rsp_overflow
);

   localparam int PB = ldrt_pkg::POS_BITS;
   localparam int SW = ldrt_pkg::SYM_W;
   localparam int LW = ldrt_pkg::LEN_W;
   localparam int CW = ldrt_pkg::LEN_CALC_W;

   logic [PB-1:0] last_pos_mem [ldrt_pkg::ALPHABET_SIZE];

   logic                           s2_valid_ff;
   logic [SW-1:0]                  s2_sym_ff;
   logic                           s2_first_ff;
   logic [PB-1:0]                  rd_last_ff;

   logic [ldrt_pkg::ALPHABET_SIZE-1:0] seen_ff, seen_in;
   logic [PB:0]                    pos_ff, pos_in;
   logic [PB-1:0]                  ws_ff, ws_in;
   logic [LW-1:0]                  best_ff, best_in;
   logic                           ovf_ff, ovf_in;

   logic                           rsp_valid_ff;
   logic [LW-1:0]                  rsp_window_len_ff, rsp_longest_len_ff;
   logic                           rsp_overflow_ff;

   logic                           req_accept, s2_adv;
   logic [SW-1:0]                  req_sym;
   logic [PB:0]                    pos_cur;
   logic [PB-1:0]                  ws_cur, idx, next_start;
   logic [LW-1:0]                  best_cur, len16;
   logic                           ovf_cur, sat, seen_cur, hit;
   logic [CW-1:0]                  len;

   assign s2_adv     = s2_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall  = s2_valid_ff && !s2_adv;
   assign req_accept = req_valid && !req_stall;
   assign req_sym    = ldrt_pkg::sym_of(req_ch);

   // A first flag clears history before its own byte is handled.
   always_comb begin
      pos_cur  = s2_first_ff ? '0 : pos_ff;
      ws_cur   = s2_first_ff ? '0 : ws_ff;
      best_cur = s2_first_ff ? '0 : best_ff;
      ovf_cur  = s2_first_ff ? 1'b0 : ovf_ff;
      seen_cur = !s2_first_ff && seen_ff[s2_sym_ff];

      sat    = pos_cur[PB];
      idx    = sat ? ldrt_pkg::POS_MAX : pos_cur[PB-1:0];
      pos_in = sat ? pos_cur : pos_cur + (PB+1)'(1);
      ovf_in = ovf_cur || sat;

      hit        = seen_cur && (rd_last_ff >= ws_cur);
      next_start = (rd_last_ff == ldrt_pkg::POS_MAX) ? ldrt_pkg::POS_MAX
                                                     : rd_last_ff + PB'(1);
      ws_in      = hit ? next_start : ws_cur;

      len   = (ws_in <= idx) ? (CW'(idx) - CW'(ws_in) + CW'(1)) : CW'(1);
      len16 = (len > CW'(ldrt_pkg::LEN_MAX)) ? ldrt_pkg::LEN_MAX : len[LW-1:0];
      best_in = (len16 > best_cur) ? len16 : best_cur;

      seen_in = s2_first_ff ? '0 : seen_ff;
      seen_in[s2_sym_ff] = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         seen_ff      <= '0;
         pos_ff       <= '0;
         ws_ff        <= '0;
         best_ff      <= '0;
         ovf_ff       <= 1'b0;
      end else begin
         if (req_accept) begin
            s2_valid_ff <= 1'b1;
         end else if (s2_adv) begin
            s2_valid_ff <= 1'b0;
         end
         if (s2_adv) begin
            rsp_valid_ff <= 1'b1;
            seen_ff      <= seen_in;
            pos_ff       <= pos_in;
            ws_ff        <= ws_in;
            best_ff      <= best_in;
            ovf_ff       <= ovf_in;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s2_sym_ff   <= req_sym;
         s2_first_ff <= req_first;
      end
      if (s2_adv) begin
         rsp_window_len_ff  <= len16;
         rsp_longest_len_ff <= best_in;
         rsp_overflow_ff    <= ovf_in;
      end
   end

   // The write of the item ahead is forwarded when it hits the entry being read.
   always_ff @(posedge clock) begin
      if (s2_adv) begin
         last_pos_mem[s2_sym_ff] <= idx;
      end
      if (req_accept) begin
         if (s2_adv && s2_sym_ff == req_sym) begin
            rd_last_ff <= idx;
         end else begin
            rd_last_ff <= last_pos_mem[req_sym];
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_window_len  = rsp_window_len_ff;
   assign rsp_longest_len = rsp_longest_len_ff;
   assign rsp_overflow    = rsp_overflow_ff;

   a_longest_covers_window: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_longest_len >= rsp_window_len)
      else $error("longest length below window length");

   a_window_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_window_len != '0)
      else $error("empty window reported");

   a_start_not_past_index: assert property (@(posedge clock) disable iff (reset)
      s2_adv |-> ws_in <= idx)
      else $error("window start beyond current index");

   a_position_bounded: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= (PB+1)'(ldrt_pkg::POS_MAX) + (PB+1)'(1))
      else $error("position counter ran past its stop");

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s2_valid_ff && rsp_valid_ff && rsp_stall)
      else $error("input stalled without a held item");

endmodule

FILE: verif/longest_distinct_run_tracker_tb.sv
// Self-checking testbench for the longest distinct-byte run tracker.
module longest_distinct_run_tracker_tb;

   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int HOLD_CYCLES   = 300;
   localparam int RANDOM_BYTES  = 1230;
   localparam int SETTLE_CYCLES = 20;

   typedef struct packed {
      logic [ldrt_pkg::LEN_W-1:0] window_len;
      logic [ldrt_pkg::LEN_W-1:0] longest_len;
      logic                       overflow;
   } run_lengths_type;

   // Tracks the run state byte by byte and holds the lengths still owed by the block.
   class distinct_run_checker;
      bit                            seen [ldrt_pkg::ALPHABET_SIZE];
      logic [ldrt_pkg::POS_BITS-1:0] last_pos [ldrt_pkg::ALPHABET_SIZE];
      logic [ldrt_pkg::POS_BITS:0]   pos_count;
      logic [ldrt_pkg::POS_BITS-1:0] win_start;
      logic [ldrt_pkg::LEN_W-1:0]    best;
      logic                          overflowed;
      run_lengths_type               expected_lengths [$];
      int                            errors;

      function new();
         errors = 0;
         clear_history();
      endfunction

      function void clear_history();
         foreach (seen[i]) begin
            seen[i]     = 1'b0;
            last_pos[i] = '0;
         end
         pos_count  = '0;
         win_start  = '0;
         best       = '0;
         overflowed = 1'b0;
      endfunction

      function int pending();
         return expected_lengths.size();
      endfunction

      function void note_byte(logic [ldrt_pkg::CH_W-1:0] ch, logic first);
         int unsigned       sym;
         longint unsigned   idx;
         longint unsigned   next_start;
         longint unsigned   run;
         run_lengths_type   lengths;
         sym = ch % ldrt_pkg::ALPHABET_SIZE;
         if (first) clear_history();
         // Past the end of the counter every byte shares the last index.
         if (pos_count > ldrt_pkg::POS_MAX) begin
            idx        = 64'(ldrt_pkg::POS_MAX);
            overflowed = 1'b1;
         end else begin
            idx       = 64'(pos_count);
            pos_count = pos_count + 1'b1;
         end
         // Only a repeat inside the current window moves its start.
         if (seen[sym] && last_pos[sym] >= win_start) begin
            next_start = 64'(last_pos[sym]);
            next_start = next_start + 64'd1;
            win_start  = (next_start > 64'(ldrt_pkg::POS_MAX)) ? ldrt_pkg::POS_MAX
                                                               : next_start[ldrt_pkg::POS_BITS-1:0];
         end
         seen[sym]     = 1'b1;
         last_pos[sym] = idx[ldrt_pkg::POS_BITS-1:0];
         run = (64'(win_start) <= idx) ? idx - 64'(win_start) + 64'd1 : 64'd1;
         lengths.window_len = (run > 64'(ldrt_pkg::LEN_MAX)) ? ldrt_pkg::LEN_MAX
                                                             : run[ldrt_pkg::LEN_W-1:0];
         if (lengths.window_len > best) best = lengths.window_len;
         lengths.longest_len = best;
         lengths.overflow    = overflowed;
         expected_lengths.push_back(lengths);
      endfunction

      function void check_lengths(logic [ldrt_pkg::LEN_W-1:0] window_len,
                                  logic [ldrt_pkg::LEN_W-1:0] longest_len,
                                  logic overflow);
         run_lengths_type want;
         if (expected_lengths.size() == 0) begin
            $display("%0t: result with no byte outstanding: window %0d longest %0d overflow %0b",
                     $time, window_len, longest_len, overflow);
            errors++;
            return;
         end
         want = expected_lengths.pop_front();
         if (window_len !== want.window_len) begin
            $display("%0t: window_len expected %0d actual %0d", $time, want.window_len,
                     window_len);
            errors++;
         end
         if (longest_len !== want.longest_len) begin
            $display("%0t: longest_len expected %0d actual %0d", $time, want.longest_len,
                     longest_len);
            errors++;
         end
         if (overflow !== want.overflow) begin
            $display("%0t: overflow expected %0b actual %0b", $time, want.overflow, overflow);
            errors++;
         end
      endfunction
   endclass

   logic                        clock;
   logic                        reset     = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_stall;
   logic [ldrt_pkg::CH_W-1:0]   req_ch    = '0;
   logic                        req_first = 1'b0;
   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   logic [ldrt_pkg::LEN_W-1:0]  rsp_window_len;
   logic [ldrt_pkg::LEN_W-1:0]  rsp_longest_len;
   logic                        rsp_overflow;

   distinct_run_checker tracker = new();

   int  cycle_count   = 0;
   int  hold_requests = 0;
   int  burst_left    = 0;
   int  bytes_sent    = 0;
   bit  offering      = 1'b0;
   bit  sender_fast   = 1'b0;

   longest_distinct_run_tracker dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_ch          (req_ch),
      .req_first       (req_first),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_window_len  (rsp_window_len),
      .rsp_longest_len (rsp_longest_len),
      .rsp_overflow    (rsp_overflow)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("longest_distinct_run_tracker test failed");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         tracker.check_lengths(rsp_window_len, rsp_longest_len, rsp_overflow);
      end
   end

   // Receiver: stretches of random length, each with its own stall rate, plus long
   // hold-offs on request.
   initial begin
      int stretch;
      int pct;
      int hold_served;
      hold_served = 0;
      forever begin
         stretch = $urandom_range(40, 1);
         case ($urandom_range(3))
            0: pct = 0;
            1: pct = 25;
            2: pct = 60;
            default: pct = 90;
         endcase
         repeat (stretch) begin
            @(posedge clock);
            if (hold_requests != hold_served) begin
               hold_served++;
               rsp_stall <= 1'b1;
               repeat (HOLD_CYCLES) @(posedge clock);
            end
            rsp_stall <= ($urandom_range(99) < pct);
         end
      end
   end

   task automatic lower_valid();
      if (offering) begin
         req_valid <= 1'b0;
         offering = 1'b0;
      end
   endtask

   task automatic pace_sender();
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
         burst_left = $urandom_range(30, 1);
         if (!sender_fast) begin
            lower_valid();
            repeat ($urandom_range(8, 1)) @(posedge clock);
         end
      end
   endtask

   task automatic send_byte(input logic [ldrt_pkg::CH_W-1:0] ch, input logic first);
      req_valid <= 1'b1;
      req_ch    <= ch;
      req_first <= first;
      offering = 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      tracker.note_byte(ch, first);
      bytes_sent++;
      pace_sender();
   endtask

   task automatic send_text(input string text);
      for (int i = 0; i < text.len(); i++) begin
         send_byte(text[i], i == 0);
      end
   endtask

   // A string either walks a shuffled alphabet, so runs grow to the full alphabet,
   // or draws from a band of 2 to 256 byte values, so repeats are frequent in the narrow bands.
   task automatic send_string(input int len, input bit lead_first, input bit noise);
      logic [ldrt_pkg::CH_W-1:0] perm [1 << ldrt_pkg::CH_W];
      logic [ldrt_pkg::CH_W-1:0] tmp;
      logic [ldrt_pkg::CH_W-1:0] ch;
      bit                        walk;
      int                        span;
      int                        base;
      int                        k;
      walk = ($urandom_range(3) == 0);
      case ($urandom_range(4))
         0: span = 2;
         1: span = 3;
         2: span = 8;
         3: span = 32;
         default: span = 256;
      endcase
      base = $urandom_range(255);
      foreach (perm[i]) perm[i] = ldrt_pkg::CH_W'(i);
      for (int i = $size(perm) - 1; i > 0; i--) begin
         k       = $urandom_range(i);
         tmp     = perm[i];
         perm[i] = perm[k];
         perm[k] = tmp;
      end
      for (int i = 0; i < len; i++) begin
         if (walk) ch = perm[i % $size(perm)];
         else ch = ldrt_pkg::CH_W'(base + $urandom_range(span - 1));
         send_byte(ch, (i == 0 && lead_first) || (noise && $urandom_range(49) == 0));
      end
   endtask

   task automatic wait_for_results();
      lower_valid();
      while (tracker.pending() != 0) @(posedge clock);
   endtask

   initial begin
      int  start_count;
      int  len;
      bit  paused;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // No first flag after reset, extreme byte values and immediate repeats.
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_text("abcabcbb");
      send_text("pwwkew");
      send_text("aa");
      // The second a was seen before the window start, so the window stays.
      send_text("abba");
      wait_for_results();

      // Long receiver hold-off while the sender keeps offering bytes back to back.
      sender_fast = 1'b1;
      hold_requests++;
      send_string(60, 1'b1, 1'b0);
      sender_fast = 1'b0;

      start_count = bytes_sent;
      paused      = 1'b0;
      while (bytes_sent - start_count < RANDOM_BYTES) begin
         len = ($urandom_range(9) == 0) ? $urandom_range(320, 200) : $urandom_range(60, 1);
         if (len > RANDOM_BYTES - (bytes_sent - start_count)) begin
            len = RANDOM_BYTES - (bytes_sent - start_count);
         end
         send_string(len, $urandom_range(9) != 0, 1'b1);
         if (!paused && bytes_sent - start_count >= RANDOM_BYTES / 2) begin
            wait_for_results();
            paused = 1'b1;
         end
      end

      send_string(30, 1'b1, 1'b0);
      send_text("xyzx");

      wait_for_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (tracker.errors == 0 && tracker.pending() == 0) begin
         $display("longest_distinct_run_tracker test passed");
      end else begin
         $display("longest_distinct_run_tracker test failed");
      end
      $finish;
   end

endmodule
